// File: hw/rtl/cled_pkg.sv
// Shared types and constants of the console line editor.
`default_nettype none
package cled_pkg;
    localparam logic [1:0] KIND_ECHO    = 2'd0;
    localparam logic [1:0] KIND_CMD     = 2'd1;
    localparam logic [1:0] KIND_DISCARD = 2'd2;
    localparam logic [3:0] CMD_UNKNOWN  = 4'd8;
    localparam logic [3:0] CMD_EMPTY    = 4'd9;
    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_CTRLC = 8'h03;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] ENTER_RESET = 8'd13;
    localparam int NAMES = 8;

    // Command name byte j of entry i, zero past the end of the name.
    function automatic logic [7:0] name_byte(input logic [2:0] i, input logic [3:0] j);
        logic [63:0] s;
        case (i)
            3'd0: s = {"go", 48'h0};
            3'd1: s = {"help", 32'h0};
            3'd2: s = {"nandwb", 16'h0};
            3'd3: s = "nandcopy";
            3'd4: s = {"pm", 48'h0};
            3'd5: s = {"r", 56'h0};
            3'd6: s = {"w", 56'h0};
            default: s = {"xmodem", 16'h0};
        endcase
        if (j >= 4'd8) name_byte = 8'h00;
        else name_byte = s[63 - 8*j[2:0] -: 8];
    endfunction

    // Value of a hex digit; other bytes count as zero.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") hex_val = 4'(c - "0");
        else if (c >= "A" && c <= "F") hex_val = 4'(c - "A" + 8'd10);
        else if (c >= "a" && c <= "f") hex_val = 4'(c - "a" + 8'd10);
        else hex_val = 4'd0;
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/cled_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module cled_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Registered read; during a write the old contents are returned.
    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/console_line_editor_and_command_decoder.sv
// Top level of the console line editor and command decoder.
// Usage: received console bytes arrive as beats on the s_ channel; each beat
// yields zero to three result beats on the m_ channel, the final one marked by
// m_last_flag. A stored byte is echoed in the cycle after it is accepted, and a
// backspace on a non-empty line gives three echo beats.
// ESC or Ctrl-C gives one discard beat. The enter byte starts a walk of the
// line memory: the name is compared against the table entries in turn, then
// the rest of the line is scanned once to count tokens and parse the two hex
// arguments. Every byte looked at is first read from the memory, then compared,
// and the record beat is produced when the walk ends.
// One byte is handled at a time; s_ready is low while a byte's results are
// being produced or while a result waits for m_ready. A stalled receiver
// holds the result beat unchanged and blocks further input.
// Reset clears the fill count (empty line) and sets the enter byte to 13;
// the line memory is not cleared, since only written entries are read.
// The enter byte register lies at APB address 0.
`default_nettype none
module console_line_editor_and_command_decoder #(
    parameter int LINE_DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [1:0]  m_kind,
    output logic      [7:0]  m_out_byte,
    output logic      [3:0]  m_cmd_id,
    output logic      [5:0]  m_token_count,
    output logic      [31:0] m_first_arg,
    output logic      [31:0] m_second_arg,
    output logic             m_last_flag
);
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(LINE_DEPTH - 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_OUT    = 4'd1;
    localparam logic [3:0] ST_BS2    = 4'd2;
    localparam logic [3:0] ST_BS3    = 4'd3;
    localparam logic [3:0] ST_NREQ   = 4'd4;
    localparam logic [3:0] ST_NCMP   = 4'd5;
    localparam logic [3:0] ST_SREQ   = 4'd6;
    localparam logic [3:0] ST_SCAN   = 4'd7;
    localparam logic [3:0] ST_REC    = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [7:0]    enter_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] pos_reg;
    logic [3:0]    j_reg;
    logic [2:0]    ent_reg;
    logic [3:0]    id_reg;
    logic          prev_sp_reg;
    logic [5:0]    tok_reg;
    logic [1:0]    arg_reg;      // 1 in arg1, 2 in arg2, 3 done; 0 is not used
    logic [3:0]    dig_reg;
    logic          skip_reg;     // skipping leading spaces of current argument
    logic [31:0]   a1_reg, a2_reg;

    // APB register port.
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {24'd0, enter_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) enter_reg <= cled_pkg::ENTER_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0) enter_reg <= pwdata[7:0];
    end

    // Line memory.
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_rdata;
    cled_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(s_rx_byte), .rdata(ram_rdata)
    );

    logic accept;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    logic is_enter, is_esc, is_bs;
    assign is_enter = s_rx_byte == enter_reg;
    assign is_esc   = s_rx_byte == cled_pkg::CH_ESC || s_rx_byte == cled_pkg::CH_CTRLC;
    assign is_bs    = s_rx_byte == cled_pkg::CH_BS;
    assign ram_we   = accept && !is_enter && !is_esc && !is_bs && fill_reg < FULL;

    always_comb begin
        if (ram_we) ram_addr = fill_reg[AW-1:0];
        else if (state_reg == ST_NREQ) ram_addr = AW'(j_reg);
        else ram_addr = pos_reg[AW-1:0];
    end

    // Byte seen by the walk, zero beyond the line.
    logic [CW-1:0] rd_pos;
    logic [7:0]    ch;
    assign rd_pos = (state_reg == ST_NCMP) ? CW'(j_reg) : pos_reg;
    assign ch = (rd_pos < fill_reg) ? ram_rdata : 8'h00;
    logic [7:0] nb;
    assign nb = cled_pkg::name_byte(ent_reg, j_reg);

    logic out_fire;
    assign out_fire = m_valid && m_ready;

    // Main sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            m_valid   <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        m_out_byte    <= 8'h00;
                        m_cmd_id      <= 4'd0;
                        m_token_count <= 6'd0;
                        m_first_arg   <= 32'd0;
                        m_second_arg  <= 32'd0;
                        m_last_flag   <= 1'b1;
                        if (is_enter) begin
                            ent_reg   <= 3'd0;
                            j_reg     <= 4'd0;
                            state_reg <= ST_NREQ;
                        end else if (is_esc) begin
                            fill_reg  <= '0;
                            m_kind    <= cled_pkg::KIND_DISCARD;
                            m_valid   <= 1'b1;
                            state_reg <= ST_OUT;
                        end else if (is_bs) begin
                            if (fill_reg != '0) begin
                                fill_reg    <= fill_reg - 1'b1;
                                m_kind      <= cled_pkg::KIND_ECHO;
                                m_out_byte  <= cled_pkg::CH_BS;
                                m_last_flag <= 1'b0;
                                m_valid     <= 1'b1;
                                state_reg   <= ST_BS2;
                            end
                        end else if (fill_reg < FULL) begin
                            fill_reg   <= fill_reg + 1'b1;
                            m_kind     <= cled_pkg::KIND_ECHO;
                            m_out_byte <= s_rx_byte;
                            m_valid    <= 1'b1;
                            state_reg  <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_fire) begin
                        m_valid   <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_BS2: begin
                    if (out_fire) begin
                        m_out_byte <= cled_pkg::CH_SPACE;
                        state_reg  <= ST_BS3;
                    end
                end
                ST_BS3: begin
                    if (out_fire) begin
                        m_out_byte  <= cled_pkg::CH_BS;
                        m_last_flag <= 1'b1;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_NREQ: state_reg <= ST_NCMP;
                ST_NCMP: begin
                    // Compare one name byte; a zero line byte ends the line.
                    if (j_reg == 4'd0 && ch == 8'h00) begin
                        id_reg    <= cled_pkg::CMD_EMPTY;
                        state_reg <= ST_REC;
                    end else if (nb == 8'h00) begin
                        if (ch == cled_pkg::CH_SPACE || ch == 8'h00) begin
                            id_reg      <= {1'b0, ent_reg};
                            pos_reg     <= CW'(j_reg);
                            prev_sp_reg <= 1'b1;
                            tok_reg     <= 6'd0;
                            arg_reg     <= 2'd1;
                            skip_reg    <= 1'b1;
                            dig_reg     <= 4'd0;
                            a1_reg      <= 32'd0;
                            a2_reg      <= 32'd0;
                            state_reg   <= ST_SREQ;
                        end else if (ent_reg == 3'd7) begin
                            id_reg    <= cled_pkg::CMD_UNKNOWN;
                            state_reg <= ST_REC;
                        end else begin
                            ent_reg   <= ent_reg + 1'b1;
                            j_reg     <= 4'd0;
                            state_reg <= ST_NREQ;
                        end
                    end else if (ch == nb) begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_NREQ;
                    end else if (ent_reg == 3'd7) begin
                        id_reg    <= cled_pkg::CMD_UNKNOWN;
                        state_reg <= ST_REC;
                    end else begin
                        ent_reg   <= ent_reg + 1'b1;
                        j_reg     <= 4'd0;
                        state_reg <= ST_NREQ;
                    end
                end
                ST_SREQ: state_reg <= ST_SCAN;
                ST_SCAN: begin
                    // One byte of the argument part per visit.
                    if (ch == 8'h00) begin
                        state_reg <= ST_REC;
                    end else begin
                        if (ch != cled_pkg::CH_SPACE && prev_sp_reg && tok_reg != 6'd63)
                            tok_reg <= tok_reg + 1'b1;
                        prev_sp_reg <= (ch == cled_pkg::CH_SPACE);
                        if (arg_reg == 2'd1 || arg_reg == 2'd2) begin
                            if (ch == cled_pkg::CH_SPACE) begin
                                if (!skip_reg) begin
                                    skip_reg <= 1'b1;
                                    dig_reg  <= 4'd0;
                                    arg_reg  <= arg_reg + 1'b1;
                                end
                            end else if (skip_reg && !(dig_reg == 4'd0)) begin
                                skip_reg <= 1'b1;
                            end else begin
                                // Digit; the eighth digit closes the argument.
                                if (arg_reg == 2'd1)
                                    a1_reg <= {a1_reg[27:0], cled_pkg::hex_val(ch)};
                                else
                                    a2_reg <= {a2_reg[27:0], cled_pkg::hex_val(ch)};
                                if (dig_reg == 4'd7) begin
                                    skip_reg <= 1'b1;
                                    dig_reg  <= 4'd0;
                                    arg_reg  <= arg_reg + 1'b1;
                                end else begin
                                    skip_reg <= 1'b0;
                                    dig_reg  <= dig_reg + 1'b1;
                                end
                            end
                        end
                        pos_reg   <= pos_reg + 1'b1;
                        state_reg <= ST_SREQ;
                    end
                end
                ST_REC: begin
                    fill_reg  <= '0;
                    m_kind    <= cled_pkg::KIND_CMD;
                    m_cmd_id  <= id_reg;
                    if (id_reg[3] == 1'b0) begin
                        m_token_count <= tok_reg;
                        m_first_arg   <= a1_reg;
                        m_second_arg  <= a2_reg;
                    end
                    m_valid   <= 1'b1;
                    state_reg <= ST_OUT;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
